// ===== hw/rtl/ptb_pkg.sv =====
// shared types and codes for the periodic timer bank
package ptb_pkg;

  // command codes on the func field
  localparam logic [2:0] FN_TICK    = 3'd0;
  localparam logic [2:0] FN_SETUP   = 3'd1;
  localparam logic [2:0] FN_START   = 3'd2;
  localparam logic [2:0] FN_STOP    = 3'd3;
  localparam logic [2:0] FN_DESTROY = 3'd4;

  // item classes handed from front to back
  localparam logic [2:0] CLS_TICK    = 3'd0;
  localparam logic [2:0] CLS_SETUP   = 3'd1;
  localparam logic [2:0] CLS_START   = 3'd2;
  localparam logic [2:0] CLS_STOP    = 3'd3;
  localparam logic [2:0] CLS_DESTROY = 3'd4;
  localparam logic [2:0] CLS_NONE    = 3'd5;

  // slot lifecycle codes
  localparam logic [2:0] ST_UNUSED    = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_STARTED   = 3'd2;
  localparam logic [2:0] ST_STOPPED   = 3'd3;
  localparam logic [2:0] ST_DESTROYED = 3'd4;

  // result kinds
  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  // expiry results reported per tick
  localparam int MAX_REPORT = 8;
  localparam int REPORT_W   = 4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef struct packed {
    logic [2:0]  cls;
    logic [2:0]  slot_index;
    logic        in_range;
    logic [31:0] start_delay;
    logic [31:0] period_ticks;
  } ptb_cmd_t;

endpackage

// ===== hw/rtl/ptb_front.sv =====
// front end: accepts command beats, classifies them and queues them
module ptb_front #(
  parameter int NUM_TIMERS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  logic [2:0]        func,
  input  logic [2:0]        slot_index,
  input  logic [31:0]       start_delay,
  input  logic [31:0]       period_ticks,
  output logic              q_valid,
  output ptb_pkg::ptb_cmd_t q_head,
  input  logic              q_pop
);
  import ptb_pkg::*;

  ptb_cmd_t          queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;
  ptb_cmd_t          entry;
  logic              push;
  logic              pop;

  always_comb begin
    entry.slot_index   = slot_index;
    entry.in_range     = (32'(slot_index) < 32'(NUM_TIMERS));
    entry.start_delay  = start_delay;
    entry.period_ticks = period_ticks;
    unique case (func)
      FN_TICK:    entry.cls = CLS_TICK;
      FN_SETUP:   entry.cls = CLS_SETUP;
      FN_START:   entry.cls = CLS_START;
      FN_STOP:    entry.cls = CLS_STOP;
      FN_DESTROY: entry.cls = CLS_DESTROY;
      default:    entry.cls = CLS_NONE;
    endcase
  end

  assign cmd_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (count != '0);
  assign q_head    = queue[rptr];
  assign push      = cmd_valid && !cmd_stall;
  assign pop       = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/ptb_back.sv =====
// back end: slot storage, command execution, tick scan and result register
module ptb_back #(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  ptb_pkg::ptb_cmd_t q_head,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output logic              kind,
  output logic [2:0]        slot_id,
  output logic [2:0]        slot_state,
  output logic              fired,
  output logic              last
);
  import ptb_pkg::*;

  localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW = $clog2(NUM_TIMERS + 1);
  localparam int W  = COUNT_WIDTH;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMD  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  ptb_cmd_t   cur;

  logic [W-1:0] cnt_mem [NUM_TIMERS];
  logic [W-1:0] dly_mem [NUM_TIMERS];
  logic [W-1:0] per_mem [NUM_TIMERS];
  logic [W-1:0] rd_cnt;
  logic [W-1:0] rd_dly;
  logic [W-1:0] rd_per;
  logic [2:0]   life [NUM_TIMERS];

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          cnt_we;
  logic [SW-1:0] cnt_wa;
  logic [W-1:0]  cnt_wd;
  logic          cfg_we;

  logic [CW-1:0] scan_cnt;
  logic          p_vld;
  logic [SW-1:0] p_slot;
  logic          pend_vld;
  logic [2:0]    pend_slot;
  logic [2:0]    pend_state;
  logic [REPORT_W-1:0] n_rep;

  logic adv;
  logic scan_issue;
  logic scan_done;

  logic [SW+2:0] hd_ext;
  logic [SW+2:0] cur_ext;
  logic [SW+2:0] p_ext;
  logic [SW-1:0] hd_addr;
  logic [SW-1:0] cur_addr;
  logic [2:0]    p_id;
  logic [W+31:0] dly_ext;
  logic [W+31:0] per_ext;
  logic [W-1:0]  new_dly;
  logic [W-1:0]  new_per;
  logic [W-1:0]  load;
  logic [2:0]    st_cur;
  logic [2:0]    st_new;
  logic          cmd_load;

  logic [2:0]   s_life;
  logic         s_active;
  logic         s_fire;
  logic         s_reload;
  logic [2:0]   s_state;
  logic         s_report;

  logic         emit;
  logic         e_kind;
  logic [2:0]   e_slot;
  logic [2:0]   e_state;
  logic         e_fired;
  logic         e_last;

  assign adv = !res_valid || !res_stall;

  // index and count width fitting
  assign hd_ext   = {SW'(0), q_head.slot_index};
  assign cur_ext  = {SW'(0), cur.slot_index};
  assign p_ext    = {3'b000, p_slot};
  assign hd_addr  = hd_ext[SW-1:0];
  assign cur_addr = cur_ext[SW-1:0];
  assign p_id     = p_ext[2:0];
  assign dly_ext  = {W'(0), cur.start_delay};
  assign per_ext  = {W'(0), cur.period_ticks};
  assign new_dly  = dly_ext[W-1:0];
  assign new_per  = per_ext[W-1:0];

  assign q_pop = (state == S_IDLE) && q_valid;

  // command execution
  assign st_cur = life[cur_addr];

  always_comb begin
    if (cur.cls == CLS_SETUP) begin
      load = (new_dly != '0) ? new_dly : new_per;
    end else begin
      load = (rd_dly != '0) ? rd_dly : rd_per;
    end
  end

  always_comb begin
    st_new   = st_cur;
    cmd_load = 1'b0;
    unique case (cur.cls)
      CLS_SETUP: begin
        st_new   = ST_CREATED;
        cmd_load = 1'b1;
      end
      CLS_START: begin
        if (st_cur == ST_CREATED || st_cur == ST_STOPPED) begin
          st_new   = ST_STARTED;
          cmd_load = 1'b1;
        end
      end
      CLS_STOP: begin
        if (st_cur == ST_CREATED || st_cur == ST_STARTED) begin
          st_new = ST_STOPPED;
        end
      end
      CLS_DESTROY: st_new = ST_DESTROYED;
      default:     st_new = st_cur;
    endcase
  end

  // tick scan: read slot k while slot k-1 is evaluated
  assign scan_issue = (state == S_SCAN) && adv && (scan_cnt < CW'(NUM_TIMERS));
  assign scan_done  = (state == S_SCAN) && (scan_cnt == CW'(NUM_TIMERS)) && !p_vld;
  assign s_life     = life[p_slot];
  assign s_active   = (state == S_SCAN) && p_vld && (s_life == ST_STARTED);
  assign s_fire     = s_active && (rd_cnt == W'(0) || rd_cnt == W'(1));
  assign s_reload   = (rd_per != '0);
  assign s_state    = s_reload ? ST_STARTED : ST_STOPPED;
  assign s_report   = s_fire && (n_rep < REPORT_W'(MAX_REPORT));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = hd_addr;
    if (q_pop && q_head.cls != CLS_TICK) begin
      rd_en = 1'b1;
    end else if (scan_issue) begin
      rd_en   = 1'b1;
      rd_addr = scan_cnt[SW-1:0];
    end
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = cur_addr;
    cnt_wd = load;
    cfg_we = 1'b0;
    if (state == S_CMD && adv && cur.in_range) begin
      cnt_we = cmd_load;
      cfg_we = (cur.cls == CLS_SETUP);
    end else if (adv && s_active) begin
      cnt_we = 1'b1;
      cnt_wa = p_slot;
      if (s_fire) begin
        cnt_wd = s_reload ? rd_per : '0;
      end else begin
        cnt_wd = rd_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cfg_we) begin
      dly_mem[cur_addr] <= new_dly;
      per_mem[cur_addr] <= new_per;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_cnt <= cnt_mem[rd_addr];
      rd_dly <= dly_mem[rd_addr];
      rd_per <= per_mem[rd_addr];
    end
  end

  // result selection
  always_comb begin
    emit    = 1'b0;
    e_kind  = KIND_EXPIRY;
    e_slot  = pend_slot;
    e_state = pend_state;
    e_fired = 1'b1;
    e_last  = 1'b0;
    if (state == S_CMD) begin
      emit    = 1'b1;
      e_kind  = KIND_ACK;
      e_slot  = cur.slot_index;
      e_state = cur.in_range ? st_new : ST_UNUSED;
      e_fired = 1'b0;
      e_last  = 1'b1;
    end else if (scan_done) begin
      emit   = 1'b1;
      e_last = 1'b1;
      if (!pend_vld) begin
        e_slot  = 3'd0;
        e_state = ST_UNUSED;
        e_fired = 1'b0;
      end
    end else if (s_report && pend_vld) begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        life[i] <= ST_UNUSED;
      end
    end else if (state == S_CMD && adv && cur.in_range) begin
      life[cur_addr] <= st_new;
    end else if (adv && s_fire && !s_reload) begin
      life[p_slot] <= ST_STOPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (adv) begin
      if (s_report) begin
        pend_slot  <= p_id;
        pend_state <= s_state;
      end
      if (scan_issue) begin
        p_slot <= scan_cnt[SW-1:0];
      end
    end
    if (adv && emit) begin
      kind       <= e_kind;
      slot_id    <= e_slot;
      slot_state <= e_state;
      fired      <= e_fired;
      last       <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      p_vld     <= 1'b0;
      pend_vld  <= 1'b0;
      n_rep     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        res_valid <= emit;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            scan_cnt <= '0;
            p_vld    <= 1'b0;
            pend_vld <= 1'b0;
            n_rep    <= '0;
            state    <= (q_head.cls == CLS_TICK) ? S_SCAN : S_CMD;
          end
        end
        S_CMD: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (adv) begin
            p_vld <= scan_issue;
            if (scan_issue) begin
              scan_cnt <= scan_cnt + 1'b1;
            end
            if (s_report) begin
              pend_vld <= 1'b1;
              n_rep    <= n_rep + 1'b1;
            end
            if (scan_done) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/periodic_timer_bank_core.sv =====
// top level of the periodic timer bank
//
// A bank of NUM_TIMERS timer slots driven by command beats: set up, start,
// stop, destroy or tick. Commands enter a four-deep queue, so the command
// side keeps flowing while the executor works or the result side stalls,
// until the queue is full. A set up, start, stop or destroy passes through
// the executor's command state and returns one acknowledge beat with the
// slot's new state. A tick walks every slot through the single read port
// of the slot memories, one slot per cycle while the result side does not
// stall; it returns one expiry beat per fired slot (at most eight, in slot
// order, the final one marked last) or a single empty beat when nothing
// fired. Only slots 0 to 7 can be addressed by a command.
module periodic_timer_bank_core #(
  parameter int NUM_TIMERS  = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  logic [2:0]  func,
  input  logic [2:0]  slot_index,
  input  logic [31:0] start_delay,
  input  logic [31:0] period_ticks,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        kind,
  output logic [2:0]  slot_id,
  output logic [2:0]  slot_state,
  output logic        fired,
  output logic        last
);
  import ptb_pkg::*;

  logic     q_valid;
  logic     q_pop;
  ptb_cmd_t q_head;

  ptb_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .func         (func),
    .slot_index   (slot_index),
    .start_delay  (start_delay),
    .period_ticks (period_ticks),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop)
  );

  ptb_back #(
    .NUM_TIMERS  (NUM_TIMERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .kind       (kind),
    .slot_id    (slot_id),
    .slot_state (slot_state),
    .fired      (fired),
    .last       (last)
  );

endmodule
